[rtl/mwo_pkg.sv]
// ============================================================================
// mwo_pkg: shared types and constants for the mecanum wheel odometry unit
// Widths of the window, the running sums, the shared multiplier and the
// results, the sequencer states and the saturation helper.
// ============================================================================
package mwo_pkg;

  // field widths
  localparam int CNT_W   = 16;  // encoder count delta
  localparam int OUT_W   = 16;  // every result field
  localparam int SCALE_W = 24;  // Q16 configuration factors
  localparam int Q_FRAC  = 16;  // fraction bits of the scale factors

  // moving-average window
  localparam int WIN_LEN = 5;
  localparam int WHEELS  = 4;
  localparam int SLOT_W  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int WHL_W   = $clog2(WHEELS);

  // datapath widths
  localparam int SUM_W  = CNT_W + SLOT_W;            // window sum
  localparam int SPD_W  = SUM_W + SCALE_W + 1 - Q_FRAC; // unsaturated wheel speed
  localparam int COMB_W = SPD_W + 2;                 // sum of four speeds
  localparam int PROD_W = COMB_W + SCALE_W + 1;      // shared multiplier product
  localparam int Q_W    = PROD_W - Q_FRAC;           // product after Q16 truncation

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_C2S_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SCALE = 2'd1;
  localparam logic [SCALE_W-1:0]   SCALE_RESET    = 24'd65536;

  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic signed [OUT_W-1:0] res_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SHR,
    ST_COMB,
    ST_SPIN_MUL,
    ST_SPIN_SHR,
    ST_FIN
  } state_t;

  // sequencer controls toward the datapath
  typedef struct packed {
    logic in_ready;
    logic mul_en;
    logic sel_spin;
    logic spd_we;
    logic comb_we;
    logic spin_we;
    logic out_load;
  } ctrl_t;

  // clamp a wide signed value to the 16-bit signed range
  function automatic res_t sat16(input logic signed [Q_W-1:0] x);
    logic [Q_W-OUT_W:0] top;
    top = x[Q_W-1:OUT_W-1];
    if (top == '0 || top == '1) begin
      return x[OUT_W-1:0];
    end else if (x[Q_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

[rtl/mwo_if.sv]
// ============================================================================
// mwo_in_if / mwo_out_if: valid/ready channels of the odometry unit
// One word on the input carries four count deltas; one word on the output
// carries four wheel speeds and the three chassis terms.
// ============================================================================
interface mwo_in_if;
  import mwo_pkg::*;

  logic valid;
  logic ready;
  cnt_t count_front_left;
  cnt_t count_front_right;
  cnt_t count_rear_left;
  cnt_t count_rear_right;

  modport source (
    output valid, count_front_left, count_front_right, count_rear_left,
    output count_rear_right,
    input  ready
  );
  modport sink (
    input  valid, count_front_left, count_front_right, count_rear_left,
    input  count_rear_right,
    output ready
  );
endinterface

interface mwo_out_if;
  import mwo_pkg::*;

  logic valid;
  logic ready;
  res_t speed_front_left;
  res_t speed_front_right;
  res_t speed_rear_left;
  res_t speed_rear_right;
  res_t chassis_vx;
  res_t chassis_vy;
  res_t chassis_spin;

  modport source (
    output valid, speed_front_left, speed_front_right, speed_rear_left,
    output speed_rear_right, chassis_vx, chassis_vy, chassis_spin,
    input  ready
  );
  modport sink (
    input  valid, speed_front_left, speed_front_right, speed_rear_left,
    input  speed_rear_right, chassis_vx, chassis_vy, chassis_spin,
    output ready
  );
endinterface

[rtl/mecanum_wheel_odometry_unit.sv]
// ============================================================================
// mecanum_wheel_odometry_unit: filtered wheel speeds and chassis velocity
// Five-tick moving average per wheel, Q16 scaling, mecanum forward
// kinematics, 16-bit saturation.
// ============================================================================
// One input word (four encoder deltas) is taken when the unit sits idle;
// the result is loaded in the final step, the unit is back in idle as it
// appears, and no new word is taken before the last is through. The pace
// is set by the single 30x24 multiplier, used once per wheel and once for
// the spin term, each use followed by a truncation step. The result sits
// in an output register, so the unit returns to idle while it waits to be
// taken; it stalls in its last step only if an older result is still there.
// Window and running sums are cleared by reset; no clearing pass is needed.
// Configuration writes are taken in any cycle and should be made while idle.
module mecanum_wheel_odometry_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mwo_in_if.sink                                in_if,
  mwo_out_if.source                             out_if,
  input  logic                                  cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mwo_pkg::SCALE_W-1:0]           cfg_wdata
);
  import mwo_pkg::*;

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic [SCALE_W-1:0] c2s_scale_r;
  logic [SCALE_W-1:0] spin_scale_r;

  cnt_t                     cnt [WHEELS];
  cnt_t                     win_r [WHEELS][WIN_LEN];
  logic [SLOT_W-1:0]        slot_r;
  logic signed [SUM_W-1:0]  sum_r [WHEELS];
  logic signed [SUM_W-1:0]  sum_nxt [WHEELS];
  logic [WHL_W-1:0]         idx_r;
  logic                     in_acc;

  logic signed [SPD_W-1:0]  spd_r [WHEELS];
  logic signed [COMB_W-1:0] spd_x [WHEELS];
  logic signed [COMB_W-1:0] tot_x, tot_y, tot_w;
  logic signed [COMB_W-1:0] adj_x, adj_y;
  logic signed [COMB_W-1:0] comb_r;
  res_t                     vx_r, vy_r, spin_r;

  logic signed [COMB_W-1:0] mul_a;
  logic        [SCALE_W-1:0] mul_b;
  logic signed [Q_W-1:0]    mul_q;

  logic                     out_valid_r;
  res_t                     out_spd_r [WHEELS];
  res_t                     out_vx_r, out_vy_r, out_spin_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2s_scale_r  <= SCALE_RESET;
      spin_scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_C2S_SCALE:  c2s_scale_r  <= cfg_wdata;
        CFG_SPIN_SCALE: spin_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_if.valid) state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_SHR;
      ST_SHR:      state_nxt = (idx_r == WHL_W'(WHEELS-1)) ? ST_COMB : ST_MUL;
      ST_COMB:     state_nxt = ST_SPIN_MUL;
      ST_SPIN_MUL: state_nxt = ST_SPIN_SHR;
      ST_SPIN_SHR: state_nxt = ST_FIN;
      ST_FIN:      if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE:     ctrl.in_ready = 1'b1;
      ST_MUL:      ctrl.mul_en   = 1'b1;
      ST_SHR:      ctrl.spd_we   = 1'b1;
      ST_COMB:     ctrl.comb_we  = 1'b1;
      ST_SPIN_MUL: begin
        ctrl.mul_en   = 1'b1;
        ctrl.sel_spin = 1'b1;
      end
      ST_SPIN_SHR: ctrl.spin_we  = 1'b1;
      ST_FIN:      ctrl.out_load = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  assign in_if.ready = ctrl.in_ready;
  assign in_acc      = in_if.valid && ctrl.in_ready;

  // ---------------------------------------------------------------- window
  assign cnt[0] = in_if.count_front_left;
  assign cnt[1] = in_if.count_front_right;
  assign cnt[2] = in_if.count_rear_left;
  assign cnt[3] = in_if.count_rear_right;

  // running sum: drop the oldest delta, add the new one
  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      sum_nxt[w] = sum_r[w]
                 - {{(SUM_W-CNT_W){win_r[w][slot_r][CNT_W-1]}}, win_r[w][slot_r]}
                 + {{(SUM_W-CNT_W){cnt[w][CNT_W-1]}}, cnt[w]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int w = 0; w < WHEELS; w++) begin
        sum_r[w] <= '0;
        for (int k = 0; k < WIN_LEN; k++) begin
          win_r[w][k] <= '0;
        end
      end
    end else if (in_acc) begin
      slot_r <= (slot_r == SLOT_W'(WIN_LEN-1)) ? '0 : slot_r + 1'b1;
      for (int w = 0; w < WHEELS; w++) begin
        sum_r[w]         <= sum_nxt[w];
        win_r[w][slot_r] <= cnt[w];
      end
    end
  end

  // wheel counter for the multiply loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (in_acc) begin
      idx_r <= '0;
    end else if (ctrl.spd_we) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  assign mul_a = ctrl.sel_spin ? comb_r
               : {{(COMB_W-SUM_W){sum_r[idx_r][SUM_W-1]}}, sum_r[idx_r]};
  assign mul_b = ctrl.sel_spin ? spin_scale_r : c2s_scale_r;

  mwo_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  // wheel speed capture; magnitude fits SPD_W
  always_ff @(posedge clk) begin
    if (ctrl.spd_we) begin
      spd_r[idx_r] <= mul_q[SPD_W-1:0];
    end
  end

  // ---------------------------------------------------------------- kinematics
  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      spd_x[w] = {{(COMB_W-SPD_W){spd_r[w][SPD_W-1]}}, spd_r[w]};
    end
    tot_x = spd_x[0] + spd_x[1] + spd_x[2] + spd_x[3];
    tot_y = spd_x[1] + spd_x[2] - spd_x[0] - spd_x[3];
    tot_w = spd_x[1] + spd_x[3] - spd_x[0] - spd_x[2];
    // divide by four toward zero
    adj_x = tot_x + {{(COMB_W-2){1'b0}}, {2{tot_x[COMB_W-1]}}};
    adj_y = tot_y + {{(COMB_W-2){1'b0}}, {2{tot_y[COMB_W-1]}}};
  end

  always_ff @(posedge clk) begin
    if (ctrl.comb_we) begin
      comb_r <= tot_w;
      vx_r   <= sat16({{(Q_W-COMB_W+2){adj_x[COMB_W-1]}}, adj_x[COMB_W-1:2]});
      vy_r   <= sat16({{(Q_W-COMB_W+2){adj_y[COMB_W-1]}}, adj_y[COMB_W-1:2]});
    end
    if (ctrl.spin_we) begin
      spin_r <= sat16(mul_q);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      for (int w = 0; w < WHEELS; w++) begin
        out_spd_r[w] <= sat16({{(Q_W-SPD_W){spd_r[w][SPD_W-1]}}, spd_r[w]});
      end
      out_vx_r   <= vx_r;
      out_vy_r   <= vy_r;
      out_spin_r <= spin_r;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.speed_front_left  = out_spd_r[0];
  assign out_if.speed_front_right = out_spd_r[1];
  assign out_if.speed_rear_left   = out_spd_r[2];
  assign out_if.speed_rear_right  = out_spd_r[3];
  assign out_if.chassis_vx        = out_vx_r;
  assign out_if.chassis_vy        = out_vy_r;
  assign out_if.chassis_spin      = out_spin_r;

  // ---------------------------------------------------------------- checks
  // running sums must track the window contents
  logic signed [SUM_W-1:0] win_sum_chk [WHEELS];
  logic                    sum_ok;

  always_comb begin
    sum_ok = 1'b1;
    for (int w = 0; w < WHEELS; w++) begin
      win_sum_chk[w] = '0;
      for (int k = 0; k < WIN_LEN; k++) begin
        win_sum_chk[w] = win_sum_chk[w]
                       + {{(SUM_W-CNT_W){win_r[w][k][CNT_W-1]}}, win_r[w][k]};
      end
      if (win_sum_chk[w] != sum_r[w]) sum_ok = 1'b0;
    end
  end

  a_sum_tracks_window: assert property (@(posedge clk) disable iff (!rst_n)
    sum_ok)
    else $error("running sum differs from window contents");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(WIN_LEN-1))
    else $error("window slot out of range");

  a_accept_starts_loop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL) && (idx_r == '0))
    else $error("accepted word did not start the multiply loop");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word raised outside the final step");

endmodule

[rtl/mwo_mul.sv]
// ============================================================================
// mwo_mul: shared Q16 multiplier
// Signed operand times unsigned 24-bit factor, product registered, then
// divided by 65536 with truncation toward zero.
// ============================================================================
module mwo_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [mwo_pkg::COMB_W-1:0]    a,
  input  logic        [mwo_pkg::SCALE_W-1:0]   b,
  output logic signed [mwo_pkg::Q_W-1:0]       q
);
  import mwo_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] adj;

  // multiply, factor zero-extended to signed
  assign prod_nxt = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // bias negatives by 2^16-1 so the shift truncates toward zero
  assign adj = prod_r + {{(PROD_W-Q_FRAC){1'b0}}, {Q_FRAC{prod_r[PROD_W-1]}}};
  assign q   = adj[PROD_W-1:Q_FRAC];

endmodule
